>>> hdl/rffap_pkg.sv
package rffap_pkg;

  // item kinds
  localparam logic [3:0] K_WORD_WR  = 4'd0;
  localparam logic [3:0] K_WORD_RD  = 4'd1;
  localparam logic [3:0] K_RAW_WR   = 4'd2;
  localparam logic [3:0] K_RAW_RD   = 4'd3;
  localparam logic [3:0] K_HW_WR    = 4'd4;
  localparam logic [3:0] K_HW_RD    = 4'd5;
  localparam logic [3:0] K_HW_REG_WR = 4'd6;
  localparam logic [3:0] K_HW_REG_RD = 4'd7;
  localparam logic [3:0] K_SW_WR    = 4'd8;
  localparam logic [3:0] K_SW_RD    = 4'd9;
  localparam logic [3:0] K_SW_REG_WR = 4'd10;
  localparam logic [3:0] K_SW_REG_RD = 4'd11;
  localparam logic [3:0] K_DEFINE   = 4'd12;
  localparam logic [3:0] K_ATTACH   = 4'd13;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_RANGE   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_BAD_DEF = 2'd3;

  // flag bits
  localparam int FB_HW_RD  = 0;
  localparam int FB_HW_WR  = 1;
  localparam int FB_HW_EN  = 2;
  localparam int FB_HW_MSK = 3;
  localparam int FB_SW_RD  = 4;
  localparam int FB_SW_WR  = 5;
  localparam int FB_CLR_RD = 6;
  localparam int FB_SET_RD = 7;
  localparam int FB_W1S    = 8;
  localparam int FB_W1C    = 9;

  // field operations
  localparam logic [2:0] OP_RAW_WR = 3'd0;
  localparam logic [2:0] OP_RAW_RD = 3'd1;
  localparam logic [2:0] OP_HW_WR  = 3'd2;
  localparam logic [2:0] OP_HW_RD  = 3'd3;
  localparam logic [2:0] OP_SW_WR  = 3'd4;
  localparam logic [2:0] OP_SW_RD  = 3'd5;

  // config register indexes (paddr[2])
  localparam logic CFG_RESOURCES = 1'b0;
  localparam logic CFG_REGISTERS = 1'b1;

  localparam logic [31:0] ALL_ONES = 32'hffffffff;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  resource_index;
    logic [6:0]  field_index;
    logic [31:0] data;
    logic [4:0]  field_msb;
    logic [4:0]  field_lsb;
    logic [31:0] field_reset;
    logic [31:0] field_mask;
    logic [9:0]  field_flags;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic [9:0]  flags;
    logic [4:0]  msb;
    logic [4:0]  lsb;
    logic [31:0] rst;
    logic [31:0] mask;
  } field_info_t;

  localparam field_info_t FIELD_RESET_INFO = '{
    flags: 10'b0000110011, msb: 5'd0, lsb: 5'd0, rst: 32'd0, mask: 32'd0};

  typedef struct packed {
    logic [31:0] word;
    logic [31:0] value;
  } fop_res_t;

  typedef struct packed {
    logic latch;
    logic clr_step;
    logic exec;
    logic loop;
    logic lwait;
    logic fop;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic go_loop;
    logic last;
  } dp_sts_t;

  function automatic logic [31:0] width_mask(input field_info_t fi);
    logic [31:0] m;
    m = (fi.msb < fi.lsb) ? 32'd0 : (ALL_ONES >> (5'd31 - (fi.msb - fi.lsb)));
    return m;
  endfunction

  function automatic fop_res_t field_op(input logic [2:0] op, input logic [31:0] word,
                                        input field_info_t fi, input logic [31:0] v);
    logic [31:0] wm;
    logic [31:0] fm;
    logic [31:0] cur;
    logic [31:0] en;
    logic [31:0] nv;
    fop_res_t r;
    wm = width_mask(fi);
    fm = wm << fi.lsb;
    cur = (word >> fi.lsb) & wm;
    en = fm;
    nv = v;
    r.word = word;
    r.value = 32'd0;
    case (op)
      OP_RAW_WR: r.word = (word & ~fm) | ((v << fi.lsb) & fm);
      OP_RAW_RD: r.value = cur;
      OP_HW_WR: begin
        if (fi.flags[FB_HW_WR]) begin
          if (fi.flags[FB_HW_EN]) en = (fi.mask << fi.lsb) & fm;
          else if (fi.flags[FB_HW_MSK]) en = ~(fi.mask << fi.lsb) & fm;
          r.word = (word & ~en) | ((v << fi.lsb) & en);
        end
      end
      OP_HW_RD: if (fi.flags[FB_HW_RD]) r.value = cur;
      OP_SW_WR: begin
        if (fi.flags[FB_SW_WR]) begin
          if (fi.flags[FB_W1S]) nv = cur | v;
          else if (fi.flags[FB_W1C]) nv = cur & ~v;
          r.word = (word & ~fm) | ((nv << fi.lsb) & fm);
        end
      end
      OP_SW_RD: begin
        if (fi.flags[FB_SW_RD]) begin
          r.value = cur;
          if (fi.flags[FB_SET_RD]) r.word = word | fm;
          else if (fi.flags[FB_CLR_RD]) r.word = word & ~fm;
        end
      end
      default: r.word = word;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/rffap_ram.sv
module rffap_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/rffap_datapath.sv
module rffap_datapath #(
  parameter int WORD_COUNT = 256,
  parameter int MAX_REGISTERS = 64,
  parameter int MAX_FIELDS = 128,
  parameter int FIELDS_PER_REGISTER = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rffap_pkg::in_item_t  in_item,
  input  logic [8:0]           resources_in_use,
  input  logic [6:0]           registers_in_use,
  input  rffap_pkg::dp_cmd_t   cmd,
  output rffap_pkg::dp_sts_t   sts,
  output rffap_pkg::out_item_t out_item
);
  import rffap_pkg::*;

  localparam int WAW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int FAW = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
  localparam int RAW = (MAX_REGISTERS > 1) ? $clog2(MAX_REGISTERS) : 1;
  localparam int LDEPTH = MAX_REGISTERS * FIELDS_PER_REGISTER;
  localparam int LAW = (LDEPTH > 1) ? $clog2(LDEPTH) : 1;
  localparam int CW = $clog2(FIELDS_PER_REGISTER + 1);
  localparam int CLR_DEPTH0 = (WORD_COUNT > MAX_FIELDS) ? WORD_COUNT : MAX_FIELDS;
  localparam int CLR_DEPTH = (CLR_DEPTH0 > MAX_REGISTERS) ? CLR_DEPTH0 : MAX_REGISTERS;
  localparam int CLRW = $clog2(CLR_DEPTH + 1);
  localparam int FIW = $bits(field_info_t);

  in_item_t      item;
  logic [CLRW-1:0] clr_idx;
  logic [CW-1:0] idx;
  logic [31:0]   cur_word;
  logic [31:0]   acc;
  out_item_t     res;

  logic [31:0]   word_q;
  field_info_t   info_q;
  logic [CW-1:0] cnt_q;
  logic [FAW-1:0] list_q;

  logic          word_we;
  logic [WAW-1:0] word_waddr;
  logic [31:0]   word_wdata;
  logic          ftab_we;
  logic [FAW-1:0] ftab_waddr;
  field_info_t   ftab_wdata;
  logic [FAW-1:0] ftab_raddr;
  logic          cnt_we;
  logic [RAW-1:0] cnt_waddr;
  logic [CW-1:0] cnt_wdata;
  logic          list_we;
  logic [LAW-1:0] list_base;
  logic [LAW-1:0] list_waddr;
  logic [LAW-1:0] list_raddr;

  logic          word_ok;
  logic          reg_ok;
  logic          field_ok;
  logic [1:0]    st;
  logic          is_field_kind;
  logic          is_reg_kind;
  logic          is_reg_read;
  logic [2:0]    sop;
  logic [2:0]    lop;
  logic [31:0]   sv;
  fop_res_t      sres;
  fop_res_t      lres;
  fop_res_t      ares;
  logic [31:0]   lv;
  logic [31:0]   acc_next;
  logic [31:0]   exec_word;
  logic          exec_word_we;
  logic [31:0]   exec_rdata;
  logic [CW-1:0] n_fields;

  always_ff @(posedge clk) begin
    if (cmd.latch) item <= in_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clr_step) begin
      clr_idx <= clr_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) idx <= '0;
    else if (cmd.lwait) idx <= idx + 1'b1;
  end

  // bounds and status
  always_comb begin
    word_ok = (32'(item.resource_index) < 32'(resources_in_use)) &&
              (32'(item.resource_index) < WORD_COUNT);
    reg_ok = word_ok && (32'(item.resource_index) < 32'(registers_in_use)) &&
             (32'(item.resource_index) < MAX_REGISTERS);
    field_ok = 32'(item.field_index) < MAX_FIELDS;
    is_field_kind = (item.kind == K_RAW_WR) || (item.kind == K_RAW_RD) ||
                    (item.kind == K_HW_WR) || (item.kind == K_HW_RD) ||
                    (item.kind == K_SW_WR) || (item.kind == K_SW_RD);
    is_reg_kind = (item.kind == K_HW_REG_WR) || (item.kind == K_HW_REG_RD) ||
                  (item.kind == K_SW_REG_WR) || (item.kind == K_SW_REG_RD);
    is_reg_read = (item.kind == K_HW_REG_RD) || (item.kind == K_SW_REG_RD);
    case (item.kind)
      K_WORD_WR, K_WORD_RD: st = word_ok ? ST_OK : ST_RANGE;
      K_RAW_WR, K_RAW_RD, K_HW_WR, K_HW_RD, K_SW_WR, K_SW_RD:
        st = (word_ok && field_ok) ? ST_OK : ST_RANGE;
      K_HW_REG_WR, K_HW_REG_RD, K_SW_REG_WR, K_SW_REG_RD:
        st = reg_ok ? ST_OK : ST_RANGE;
      K_DEFINE: begin
        if (!field_ok) st = ST_RANGE;
        else if (item.field_msb < item.field_lsb) st = ST_BAD_DEF;
        else st = ST_OK;
      end
      K_ATTACH: begin
        if (!(reg_ok && field_ok)) st = ST_RANGE;
        else if (32'(cnt_q) >= FIELDS_PER_REGISTER) st = ST_FULL;
        else st = ST_OK;
      end
      default: st = ST_OK;
    endcase
  end

  // single-field operation and per-field register-loop operation
  always_comb begin
    case (item.kind)
      K_RAW_RD:    sop = OP_RAW_RD;
      K_HW_WR:     sop = OP_HW_WR;
      K_HW_RD:     sop = OP_HW_RD;
      K_SW_WR:     sop = OP_SW_WR;
      K_SW_RD:     sop = OP_SW_RD;
      default:     sop = OP_RAW_WR;
    endcase
    case (item.kind)
      K_HW_REG_WR: lop = OP_HW_WR;
      K_HW_REG_RD: lop = OP_HW_RD;
      K_SW_REG_WR: lop = OP_SW_WR;
      default:     lop = OP_SW_RD;
    endcase
    sv = (item.kind == K_ATTACH) ? info_q.rst : item.data;
    sres = field_op(sop, word_q, info_q, sv);
    exec_word = (item.kind == K_WORD_WR) ? item.data : sres.word;
    exec_word_we = (st == ST_OK) &&
                   ((item.kind == K_WORD_WR) || is_field_kind || (item.kind == K_ATTACH));
    if (st != ST_OK) exec_rdata = 32'd0;
    else if (item.kind == K_WORD_RD) exec_rdata = word_q;
    else if (is_field_kind) exec_rdata = sres.value;
    else exec_rdata = 32'd0;
    n_fields = (32'(cnt_q) > FIELDS_PER_REGISTER) ? CW'(FIELDS_PER_REGISTER) : cnt_q;
    lv = (item.data >> info_q.lsb) & width_mask(info_q);
    lres = field_op(lop, cur_word, info_q, lv);
    ares = field_op(OP_RAW_WR, acc, info_q, lres.value);
    acc_next = ares.word;
  end

  assign sts.clr_done = (clr_idx == CLRW'(CLR_DEPTH - 1));
  assign sts.go_loop = is_reg_kind && (st == ST_OK) && (n_fields != '0);
  assign sts.last = (idx == n_fields);

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      cur_word <= word_q;
      acc <= 32'd0;
      res.read_data <= exec_rdata;
      res.status <= st;
    end else if (cmd.fop) begin
      cur_word <= lres.word;
      acc <= acc_next;
      if (is_reg_read) res.read_data <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) out_item <= res;
  end

  // store addresses and write ports
  assign list_base = LAW'(LAW'(item.resource_index) * LAW'(FIELDS_PER_REGISTER));
  assign list_raddr = list_base + LAW'(idx);
  assign list_waddr = list_base + LAW'(cnt_q);
  assign list_we = cmd.exec && (item.kind == K_ATTACH) && (st == ST_OK);
  assign ftab_raddr = cmd.loop ? list_q : FAW'(item.field_index);

  always_comb begin
    word_we = 1'b0;
    word_waddr = WAW'(item.resource_index);
    word_wdata = lres.word;
    ftab_we = 1'b0;
    ftab_waddr = FAW'(item.field_index);
    ftab_wdata = '{flags: item.field_flags, msb: item.field_msb, lsb: item.field_lsb,
                   rst: item.field_reset, mask: item.field_mask};
    cnt_we = 1'b0;
    cnt_waddr = RAW'(item.resource_index);
    cnt_wdata = cnt_q + 1'b1;
    if (cmd.clr_step) begin
      word_we = 32'(clr_idx) < WORD_COUNT;
      word_waddr = WAW'(clr_idx);
      word_wdata = 32'd0;
      ftab_we = 32'(clr_idx) < MAX_FIELDS;
      ftab_waddr = FAW'(clr_idx);
      ftab_wdata = FIELD_RESET_INFO;
      cnt_we = 32'(clr_idx) < MAX_REGISTERS;
      cnt_waddr = RAW'(clr_idx);
      cnt_wdata = '0;
    end else if (cmd.exec) begin
      word_we = exec_word_we;
      word_wdata = exec_word;
      ftab_we = (item.kind == K_DEFINE) && (st == ST_OK);
      cnt_we = list_we;
    end else if (cmd.fop) begin
      word_we = 1'b1;
    end
  end

  rffap_ram #(.WIDTH(32), .DEPTH(WORD_COUNT)) u_words (
    .clk(clk), .we(word_we), .waddr(word_waddr), .wdata(word_wdata),
    .raddr(WAW'(item.resource_index)), .rdata(word_q));

  rffap_ram #(.WIDTH(FIW), .DEPTH(MAX_FIELDS)) u_ftab (
    .clk(clk), .we(ftab_we), .waddr(ftab_waddr), .wdata(ftab_wdata),
    .raddr(ftab_raddr), .rdata(info_q));

  rffap_ram #(.WIDTH(CW), .DEPTH(MAX_REGISTERS)) u_counts (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(RAW'(item.resource_index)), .rdata(cnt_q));

  rffap_ram #(.WIDTH(FAW), .DEPTH(LDEPTH)) u_lists (
    .clk(clk), .we(list_we), .waddr(list_waddr), .wdata(FAW'(item.field_index)),
    .raddr(list_raddr), .rdata(list_q));

endmodule

>>> hdl/rffap_ctrl.sv
module rffap_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output rffap_pkg::dp_cmd_t cmd,
  input  rffap_pkg::dp_sts_t sts
);
  import rffap_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_LWAIT = 3'd4;
  localparam logic [2:0] S_FOP   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd.latch    = (state == S_IDLE) && in_valid;
    cmd.clr_step = (state == S_CLEAR);
    cmd.exec     = (state == S_EXEC);
    cmd.loop     = (state == S_LWAIT) || (state == S_FOP);
    cmd.lwait    = (state == S_LWAIT);
    cmd.fop      = (state == S_FOP);
    cmd.load_out = (state == S_DONE) && (!out_valid || !out_stall);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (sts.clr_done) state_next = S_IDLE;
      S_IDLE:  if (in_valid) state_next = S_FETCH;
      S_FETCH: state_next = S_EXEC;
      S_EXEC:  state_next = sts.go_loop ? S_LWAIT : S_DONE;
      S_LWAIT: state_next = S_FOP;
      S_FOP:   state_next = sts.last ? S_DONE : S_LWAIT;
      S_DONE:  if (cmd.load_out) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  a_accept_fetch: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid) |=> state == S_FETCH)
    else $error("accepted beat did not start a fetch");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !cmd.latch && !cmd.load_out)
    else $error("activity during clearing pass");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result beat raised outside done");

  a_loop_from_exec: assert property (@(posedge clk) disable iff (rst)
    (state == S_LWAIT) |-> ($past(state) == S_EXEC || $past(state) == S_FOP))
    else $error("field loop entered out of order");

endmodule

>>> hdl/register_file_field_access_policies_top.sv
// Sequencing: an item is latched in IDLE, FETCH reads the stores, EXEC updates the word and
//   result; whole-register items then loop LWAIT/FOP per attached field (<= FIELDS_PER_REGISTER).
// DONE presents the result beat; a new item is taken only in IDLE, after that beat is loaded;
//   each field costs a list read followed by the dependent field-table read.
// Reset: rst is synchronous; afterwards a clearing pass over max(WORD_COUNT,
//   MAX_FIELDS, MAX_REGISTERS) entries runs before the first input beat is taken.
module register_file_field_access_policies_top #(
  parameter int WORD_COUNT = 256,
  parameter int MAX_REGISTERS = 64,
  parameter int MAX_FIELDS = 128,
  parameter int FIELDS_PER_REGISTER = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rffap_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rffap_pkg::out_item_t out_item,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import rffap_pkg::*;

  // config registers: resources_in_use at 0x0, registers_in_use at 0x4
  logic [8:0] resources_in_use;
  logic [6:0] registers_in_use;
  dp_cmd_t    cmd;
  dp_sts_t    sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      resources_in_use <= 9'd256;
      registers_in_use <= 7'd64;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        CFG_RESOURCES: resources_in_use <= pwdata[8:0];
        CFG_REGISTERS: registers_in_use <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  assign prdata = (paddr[2] == CFG_REGISTERS) ? {25'd0, registers_in_use}
                                              : {23'd0, resources_in_use};

  // controller sequences fetch / execute / per-field loop / result beat
  rffap_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .cmd(cmd), .sts(sts));

  // datapath holds the word store, field table, field lists and counts
  rffap_datapath #(
    .WORD_COUNT(WORD_COUNT), .MAX_REGISTERS(MAX_REGISTERS),
    .MAX_FIELDS(MAX_FIELDS), .FIELDS_PER_REGISTER(FIELDS_PER_REGISTER)
  ) u_dp (
    .clk(clk), .rst(rst), .in_item(in_item),
    .resources_in_use(resources_in_use), .registers_in_use(registers_in_use),
    .cmd(cmd), .sts(sts), .out_item(out_item));

endmodule

>>> tb/sv/tb_register_file_field_access_policies_top.sv
module tb_register_file_field_access_policies_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rffap_pkg::*;

  localparam int WORDS = 256;
  localparam int REGS = 64;
  localparam int FIELDS = 128;
  localparam int PER_REG = 8;
  localparam int IDLE_LIMIT = 20000;
  // directed table length
  localparam int NUM_DIRECTED = 24;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_item_t in_item;
  logic out_valid;
  logic out_stall;
  out_item_t out_item;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  register_file_field_access_policies_top i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // shadow copy of the block's state
  logic [31:0] words [WORDS];
  logic [9:0]  fld_flags [FIELDS];
  logic [4:0]  fld_msb [FIELDS];
  logic [4:0]  fld_lsb [FIELDS];
  logic [31:0] fld_rst [FIELDS];
  logic [31:0] fld_mask [FIELDS];
  logic [6:0]  reg_fields [REGS*PER_REG];
  int          reg_count [REGS];
  int unsigned word_limit;
  int unsigned reg_limit;

  out_item_t results_due[$];
  int errors;
  int idle_cycles;
  bit long_hold;
  bit stim_done;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [31:0] span_mask(int f);
    int w;
    if (fld_msb[f] < fld_lsb[f]) return 32'd0;
    w = int'(fld_msb[f]) - int'(fld_lsb[f]) + 1;
    return (w >= 32) ? 32'hffffffff : ((32'd1 << w) - 1);
  endfunction

  function automatic logic [31:0] extract(logic [31:0] w, int f);
    return (w >> fld_lsb[f]) & span_mask(f);
  endfunction

  function automatic logic [31:0] insert(logic [31:0] w, int f, logic [31:0] v);
    logic [31:0] fm;
    fm = span_mask(f) << fld_lsb[f];
    return (w & ~fm) | ((v << fld_lsb[f]) & fm);
  endfunction

  function automatic void hw_write(int r, int f, logic [31:0] v);
    logic [31:0] fm;
    logic [31:0] en;
    fm = span_mask(f) << fld_lsb[f];
    if (!fld_flags[f][FB_HW_WR]) return;
    if (fld_flags[f][FB_HW_EN]) en = (fld_mask[f] << fld_lsb[f]) & fm;
    else if (fld_flags[f][FB_HW_MSK]) en = ~(fld_mask[f] << fld_lsb[f]) & fm;
    else en = fm;
    words[r] = (words[r] & ~en) | ((v << fld_lsb[f]) & en);
  endfunction

  function automatic logic [31:0] hw_read(int r, int f);
    if (!fld_flags[f][FB_HW_RD]) return 32'd0;
    return extract(words[r], f);
  endfunction

  function automatic void sw_write(int r, int f, logic [31:0] v);
    logic [31:0] cur;
    logic [31:0] nv;
    if (!fld_flags[f][FB_SW_WR]) return;
    cur = extract(words[r], f);
    if (fld_flags[f][FB_W1S]) nv = cur | v;
    else if (fld_flags[f][FB_W1C]) nv = cur & ~v;
    else nv = v;
    words[r] = insert(words[r], f, nv);
  endfunction

  function automatic logic [31:0] sw_read(int r, int f);
    logic [31:0] v;
    if (!fld_flags[f][FB_SW_RD]) return 32'd0;
    v = extract(words[r], f);
    if (fld_flags[f][FB_CLR_RD]) words[r] = insert(words[r], f, 32'd0);
    if (fld_flags[f][FB_SET_RD]) words[r] = insert(words[r], f, 32'hffffffff);
    return v;
  endfunction

  // walks the attached fields in attach order
  function automatic logic [31:0] walk_register(int r, logic [3:0] k, logic [31:0] d);
    logic [31:0] acc;
    int f;
    acc = 32'd0;
    for (int i = 0; i < reg_count[r]; i++) begin
      f = int'(reg_fields[r*PER_REG + i]);
      case (k)
        K_HW_REG_WR: hw_write(r, f, extract(d, f));
        K_HW_REG_RD: acc = insert(acc, f, hw_read(r, f));
        K_SW_REG_WR: sw_write(r, f, extract(d, f));
        default:     acc = insert(acc, f, sw_read(r, f));
      endcase
    end
    return acc;
  endfunction

  function automatic void shadow_reset();
    word_limit = 256;
    reg_limit = 64;
    for (int i = 0; i < WORDS; i++) words[i] = '0;
    for (int i = 0; i < FIELDS; i++) begin
      fld_flags[i] = FIELD_RESET_INFO.flags;
      fld_msb[i] = '0;
      fld_lsb[i] = '0;
      fld_rst[i] = '0;
      fld_mask[i] = '0;
    end
    for (int i = 0; i < REGS*PER_REG; i++) reg_fields[i] = '0;
    for (int i = 0; i < REGS; i++) reg_count[i] = 0;
  endfunction

  // expected result of one item; updates the shadow state
  function automatic out_item_t predict_access(in_item_t it);
    out_item_t o;
    int unsigned wb;
    int unsigned rb;
    int r;
    int f;
    bit word_ok;
    bit reg_ok;
    o = '0;
    r = int'(it.resource_index);
    f = int'(it.field_index);
    wb = (word_limit < WORDS) ? word_limit : WORDS;
    rb = (reg_limit < REGS) ? reg_limit : REGS;
    word_ok = r < wb;
    reg_ok = word_ok && (r < rb);
    case (it.kind)
      K_WORD_WR, K_WORD_RD: begin
        if (!word_ok) o.status = ST_RANGE;
        else if (it.kind == K_WORD_WR) words[r] = it.data;
        else o.read_data = words[r];
      end
      K_RAW_WR, K_RAW_RD, K_HW_WR, K_HW_RD, K_SW_WR, K_SW_RD: begin
        if (!word_ok) o.status = ST_RANGE;
        else begin
          case (it.kind)
            K_RAW_WR: words[r] = insert(words[r], f, it.data);
            K_RAW_RD: o.read_data = extract(words[r], f);
            K_HW_WR:  hw_write(r, f, it.data);
            K_HW_RD:  o.read_data = hw_read(r, f);
            K_SW_WR:  sw_write(r, f, it.data);
            default:  o.read_data = sw_read(r, f);
          endcase
        end
      end
      K_HW_REG_WR, K_HW_REG_RD, K_SW_REG_WR, K_SW_REG_RD: begin
        if (!reg_ok) o.status = ST_RANGE;
        else begin
          o.read_data = walk_register(r, it.kind, it.data);
          if (it.kind == K_HW_REG_WR || it.kind == K_SW_REG_WR) o.read_data = '0;
        end
      end
      K_DEFINE: begin
        if (it.field_msb < it.field_lsb) o.status = ST_BAD_DEF;
        else begin
          fld_flags[f] = it.field_flags;
          fld_msb[f] = it.field_msb;
          fld_lsb[f] = it.field_lsb;
          fld_rst[f] = it.field_reset;
          fld_mask[f] = it.field_mask;
        end
      end
      K_ATTACH: begin
        if (!reg_ok) o.status = ST_RANGE;
        else if (reg_count[r] >= PER_REG) o.status = ST_FULL;
        else begin
          reg_fields[r*PER_REG + reg_count[r]] = 7'(f);
          reg_count[r]++;
          words[r] = insert(words[r], f, fld_rst[f]);
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int pick;
    it.kind = 4'($urandom_range(0, 15));
    it.resource_index = 8'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 7)
                                                      : $urandom_range(0, 255));
    it.field_index = 7'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 15)
                                                   : $urandom_range(0, 127));
    it.data = $urandom();
    it.field_lsb = 5'($urandom_range(0, 31));
    it.field_msb = 5'(($urandom_range(0, 9) < 8) ? $urandom_range(it.field_lsb, 31)
                                                 : $urandom_range(0, 31));
    it.field_reset = $urandom();
    it.field_mask = $urandom();
    it.field_flags = 10'($urandom_range(0, 1023));
    // bias toward defines and attaches so registers get populated
    pick = $urandom_range(0, 9);
    if (pick == 0) it.kind = K_DEFINE;
    else if (pick == 1) it.kind = K_ATTACH;
    return it;
  endfunction

  // directed rows: item plus an optional typed-in expectation
  typedef struct packed {
    in_item_t  item;
    bit        known;
    out_item_t result;
  } row_t;

  row_t directed [NUM_DIRECTED];
  in_item_t beats[$];

  function automatic in_item_t mk(logic [3:0] k, logic [7:0] r, logic [6:0] f, logic [31:0] d,
                                  logic [4:0] hi, logic [4:0] lo, logic [31:0] rv,
                                  logic [31:0] m, logic [9:0] fl);
    in_item_t it;
    it.kind = k; it.resource_index = r; it.field_index = f; it.data = d;
    it.field_msb = hi; it.field_lsb = lo; it.field_reset = rv; it.field_mask = m;
    it.field_flags = fl;
    return it;
  endfunction

  function automatic row_t rw(in_item_t it, bit kn, logic [31:0] rd, logic [1:0] st);
    row_t x;
    x.item = it; x.known = kn; x.result.read_data = rd; x.result.status = st;
    return x;
  endfunction

  initial begin
    directed[0]  = rw(mk(K_WORD_RD, 8'd255, 7'd0, 0, 0, 0, 0, 0, 0), 1, 32'd0, ST_OK);
    directed[1]  = rw(mk(K_WORD_WR, 8'd255, 7'd0, 32'hffffffff, 0, 0, 0, 0, 0), 1, 0, ST_OK);
    directed[2]  = rw(mk(K_WORD_RD, 8'd255, 7'd0, 0, 0, 0, 0, 0, 0), 1, 32'hffffffff, ST_OK);
    directed[3]  = rw(mk(K_DEFINE, 8'd0, 7'd127, 0, 5'd3, 5'd9, 0, 0, 0), 1, 0, ST_BAD_DEF);
    directed[4]  = rw(mk(K_DEFINE, 8'd0, 7'd1, 0, 5'd31, 5'd0, 32'h12345678,
                         32'hffff0000, 10'h3ff), 0, 0, 0);
    directed[5]  = rw(mk(K_DEFINE, 8'd0, 7'd2, 0, 5'd15, 5'd8, 32'hff,
                         32'h0f, 10'b0000111111), 0, 0, 0);
    directed[6]  = rw(mk(K_DEFINE, 8'd0, 7'd3, 0, 5'd7, 5'd4, 32'ha,
                         32'h3, 10'b1001111011), 0, 0, 0);
    directed[7]  = rw(mk(K_ATTACH, 8'd63, 7'd1, 0, 0, 0, 0, 0, 0), 0, 0, 0);
    directed[8]  = rw(mk(K_ATTACH, 8'd64, 7'd1, 0, 0, 0, 0, 0, 0), 1, 0, ST_RANGE);
    directed[9]  = rw(mk(K_ATTACH, 8'd0, 7'd2, 0, 0, 0, 0, 0, 0), 0, 0, 0);
    directed[10] = rw(mk(K_ATTACH, 8'd0, 7'd3, 0, 0, 0, 0, 0, 0), 0, 0, 0);
    directed[11] = rw(mk(K_ATTACH, 8'd0, 7'd1, 0, 0, 0, 0, 0, 0), 0, 0, 0);
    directed[12] = rw(mk(K_HW_REG_WR, 8'd0, 7'd0, 32'hdeadbeef, 0, 0, 0, 0, 0), 0, 0, 0);
    directed[13] = rw(mk(K_HW_REG_RD, 8'd0, 7'd0, 0, 0, 0, 0, 0, 0), 0, 0, 0);
    directed[14] = rw(mk(K_SW_REG_WR, 8'd0, 7'd0, 32'h0f0f0f0f, 0, 0, 0, 0, 0), 0, 0, 0);
    directed[15] = rw(mk(K_SW_REG_RD, 8'd0, 7'd0, 0, 0, 0, 0, 0, 0), 0, 0, 0);
    directed[16] = rw(mk(K_SW_REG_RD, 8'd63, 7'd0, 0, 0, 0, 0, 0, 0), 0, 0, 0);
    directed[17] = rw(mk(K_RAW_WR, 8'd5, 7'd2, 32'hffffffff, 0, 0, 0, 0, 0), 0, 0, 0);
    directed[18] = rw(mk(K_RAW_RD, 8'd5, 7'd2, 0, 0, 0, 0, 0, 0), 1, 32'hff, ST_OK);
    directed[19] = rw(mk(K_HW_WR, 8'd5, 7'd3, 32'hf, 0, 0, 0, 0, 0), 0, 0, 0);
    directed[20] = rw(mk(K_HW_RD, 8'd5, 7'd3, 0, 0, 0, 0, 0, 0), 0, 0, 0);
    directed[21] = rw(mk(K_SW_WR, 8'd5, 7'd3, 32'h5, 0, 0, 0, 0, 0), 0, 0, 0);
    directed[22] = rw(mk(K_SW_RD, 8'd5, 7'd3, 0, 0, 0, 0, 0, 0), 0, 0, 0);
    directed[23] = rw(mk(4'd15, 8'd5, 7'd3, 32'hffffffff, 0, 0, 0, 0, 0), 1, 0, ST_OK);
  end

  int directed_pos;

  // scoreboard: result beats are compared in order at the rising edge
  always @(posedge clk) begin
    out_item_t exp_res;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (in_valid && !in_stall) begin
        exp_res = predict_access(in_item);
        if (directed_pos < NUM_DIRECTED) begin
          if (directed[directed_pos].known && directed[directed_pos].result != exp_res)
            $display("%0t predictor disagrees with table row %0d", $time, directed_pos);
          if (directed[directed_pos].known) exp_res = directed[directed_pos].result;
          directed_pos = directed_pos + 1;
        end
        results_due = {results_due, exp_res};
      end
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          $display("%0t unexpected result beat: got %h/%0d", $time,
                   out_item.read_data, out_item.status);
          errors = errors + 1;
        end else begin
          exp_res = results_due.pop_front();
          if (out_item.read_data !== exp_res.read_data) begin
            $display("%0t read_data: expected %h, actual %h", $time,
                     exp_res.read_data, out_item.read_data);
            errors = errors + 1;
          end
          if (out_item.status !== exp_res.status) begin
            $display("%0t status: expected %0d, actual %0d", $time,
                     exp_res.status, out_item.status);
            errors = errors + 1;
          end
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // receiver stall pattern; one long hold-off mid-run
  initial begin
    int hold;
    out_stall = 1'b0;
    @(negedge clk);
    while (!stim_done || results_due.size() != 0) begin
      if (long_hold) begin
        out_stall <= 1'b1;
        hold = 200;
        repeat (hold) @(negedge clk);
        long_hold = 1'b0;
      end
      case ($urandom_range(0, 3))
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 1) == 0);
        default: out_stall <= ($urandom_range(0, 4) == 0);
      endcase
      @(negedge clk);
    end
    out_stall <= 1'b0;
  end

  task automatic apb_write(logic [2:0] addr, logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic drain();
    while (results_due.size() != 0) @(negedge clk);
    // settle before the next phase
    repeat (30) @(negedge clk);
  endtask

  // send one beat; valid stays up when the next beat follows without a gap
  task automatic send_beat(in_item_t it, bit keep);
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (!keep) in_valid <= 1'b0;
  endtask

  task automatic run_random(int n);
    int burst;
    int left;
    bit gap;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      if (burst > left) burst = left;
      gap = ($urandom_range(0, 2) != 0) || (burst == left);
      for (int i = 0; i < burst; i++) send_beat(random_item(), (i != burst - 1) || !gap);
      left = left - burst;
      if (gap && left > 0) repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  endtask

  task automatic set_limits(int unsigned words_n, int unsigned regs_n);
    apb_write({CFG_RESOURCES, 2'b00}, words_n);
    apb_write({CFG_REGISTERS, 2'b00}, regs_n);
    word_limit = words_n;
    reg_limit = regs_n;
  endtask

  // stimulus
  initial begin
    errors = 0;
    directed_pos = 0;
    stim_done = 1'b0;
    long_hold = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    shadow_reset();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_DIRECTED; i++)
      send_beat(directed[i].item, i != NUM_DIRECTED - 1);
    drain();

    // full-size limits, then random; long receiver stall while sender keeps pushing
    set_limits(256, 64);
    long_hold = 1'b1;
    run_random(300);
    drain();

    // tight limits: most indexes fall out of range
    set_limits(1, 0);
    run_random(150);
    drain();

    // register bound above word bound
    set_limits(12, 64);
    run_random(200);
    drain();

    set_limits(511, 127);
    run_random(350);
    drain();

    stim_done = 1'b1;
    repeat (40) @(negedge clk);
    if (errors == 0 && results_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/rffap_pkg.sv
hdl/rffap_ram.sv
hdl/rffap_datapath.sv
hdl/rffap_ctrl.sv
hdl/register_file_field_access_policies_top.sv
tb/sv/tb_register_file_field_access_policies_top.sv
